@@ rtl/core/wfr_pkg.sv @@
package wfr_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_MASK    = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic CSR_LINK_OPEN = 1'b0;
   localparam logic CSR_CAPACITY  = 1'b1;

   localparam logic [16:0] CAP_RESET = 17'd1024;
   localparam logic [16:0] CAP_MAX   = 17'd65536;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_BYTES = 3'd2;
   localparam logic [2:0] EXT64_WRAP  = 3'd0;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_AW    = $clog2(CMD_DEPTH);

   // settings seen by the parser
   typedef struct packed {
      logic        link_open;
      logic [16:0] capacity;
   } cfg_type;

   // one parsed byte: a payload byte, an end marker, both, or a reject
   typedef struct packed {
      logic        reject;
      logic        byte_v;
      logic        end_v;
      logic [7:0]  data;
      logic [3:0]  opcode;
      logic        final_bit;
      logic [16:0] length;
   } cmd_type;

endpackage

@@ rtl/core/wfr_parser.sv @@
module wfr_parser (
   input  logic             clock,
   input  logic             reset,
   input  wfr_pkg::cfg_type cfg,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   output logic             cmd_push,
   output wfr_pkg::cmd_type cmd
);

   wfr_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [63:0] remain_ff, remain_in;
   logic [1:0]  offset_ff, offset_in;
   logic [31:0] key_ff, key_in;
   logic        masked_ff, masked_in;
   logic        final_ff, final_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [16:0] kept_ff, kept_in;

   logic        live;
   logic [6:0]  len7;
   logic [63:0] ext_len;
   logic [63:0] hdr_len;
   logic [2:0]  cnt_inc;
   logic        hdr_done;
   logic        mask_done;
   logic        last_byte;
   logic        keep_byte;
   logic        masked_now;
   logic        frame_end;
   logic        end_emit;
   logic [16:0] kept_next;
   logic [7:0]  key_byte;
   logic [7:0]  data_out;

   assign live = accept && cfg.link_open;

   // decode of the current byte
   always_comb begin
      len7       = rx_byte[6:0];
      ext_len    = {remain_ff[55:0], rx_byte};
      cnt_inc    = cnt_ff + 3'd1;
      hdr_done   = 1'b0;
      hdr_len    = ext_len;
      mask_done  = 1'b0;
      last_byte  = 1'b0;
      keep_byte  = 1'b0;
      masked_now = (phase_ff == wfr_pkg::PH_HDR1) ? rx_byte[7] : masked_ff;
      if (live) begin
         case (phase_ff)
            wfr_pkg::PH_HDR1: begin
               if (len7 != wfr_pkg::LEN_EXT16 && len7 != wfr_pkg::LEN_EXT64) begin
                  hdr_done = 1'b1;
                  hdr_len  = {57'd0, len7};
               end
            end
            wfr_pkg::PH_EXT16: hdr_done = (cnt_inc == wfr_pkg::EXT16_BYTES);
            wfr_pkg::PH_EXT64: hdr_done = (cnt_inc == wfr_pkg::EXT64_WRAP);
            wfr_pkg::PH_MASK:  mask_done = (cnt_inc == wfr_pkg::KEY_BYTES);
            wfr_pkg::PH_PAYLOAD: begin
               keep_byte = (kept_ff < cfg.capacity);
               // remaining count never drops below one inside the payload
               last_byte = (remain_ff == 64'd1);
            end
            default: ;
         endcase
      end
      frame_end = (hdr_done && !masked_now && hdr_len == 64'd0)
                  || (mask_done && remain_ff == 64'd0) || last_byte;
      kept_next = keep_byte ? kept_ff + 17'd1 : kept_ff;
      end_emit  = frame_end && (final_ff || kept_next >= cfg.capacity);
      case (offset_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      data_out = masked_ff ? (rx_byte ^ key_byte) : rx_byte;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (live) begin
         case (phase_ff)
            wfr_pkg::PH_HDR0: phase_in = wfr_pkg::PH_HDR1;
            wfr_pkg::PH_HDR1: begin
               if (len7 == wfr_pkg::LEN_EXT16) begin
                  phase_in = wfr_pkg::PH_EXT16;
               end else if (len7 == wfr_pkg::LEN_EXT64) begin
                  phase_in = wfr_pkg::PH_EXT64;
               end
            end
            wfr_pkg::PH_EXT16:   phase_in = wfr_pkg::PH_EXT16;
            wfr_pkg::PH_EXT64:   phase_in = wfr_pkg::PH_EXT64;
            wfr_pkg::PH_MASK: begin
               if (mask_done) begin
                  phase_in = wfr_pkg::PH_PAYLOAD;
               end
            end
            wfr_pkg::PH_PAYLOAD: phase_in = wfr_pkg::PH_PAYLOAD;
            default:             phase_in = wfr_pkg::PH_HDR0;
         endcase
         if (hdr_done) begin
            phase_in = masked_now ? wfr_pkg::PH_MASK : wfr_pkg::PH_PAYLOAD;
         end
         if (frame_end) begin
            phase_in = wfr_pkg::PH_HDR0;
         end
      end
   end

   // frame state and command out
   always_comb begin
      cnt_in    = cnt_ff;
      remain_in = remain_ff;
      offset_in = offset_ff;
      key_in    = key_ff;
      masked_in = masked_ff;
      final_in  = final_ff;
      opcode_in = opcode_ff;
      kept_in   = kept_ff;
      if (live) begin
         case (phase_ff)
            wfr_pkg::PH_HDR0: begin
               final_in  = rx_byte[7];
               opcode_in = rx_byte[3:0];
            end
            wfr_pkg::PH_HDR1: begin
               masked_in = rx_byte[7];
               key_in    = 32'd0;
               cnt_in    = 3'd0;
               remain_in = (len7 == wfr_pkg::LEN_EXT16 || len7 == wfr_pkg::LEN_EXT64)
                           ? 64'd0 : {57'd0, len7};
            end
            wfr_pkg::PH_EXT16, wfr_pkg::PH_EXT64: begin
               remain_in = ext_len;
               cnt_in    = cnt_inc;
            end
            wfr_pkg::PH_MASK: begin
               key_in = {key_ff[23:0], rx_byte};
               cnt_in = mask_done ? 3'd0 : cnt_inc;
            end
            wfr_pkg::PH_PAYLOAD: begin
               remain_in = remain_ff - 64'd1;
               offset_in = offset_ff + 2'd1;
            end
            default: cnt_in = 3'd0;
         endcase
         if (hdr_done || frame_end) begin
            cnt_in    = 3'd0;
            offset_in = 2'd0;
         end
         kept_in = end_emit ? 17'd0 : kept_next;
      end

      cmd_push      = (accept && !cfg.link_open) || keep_byte || end_emit;
      cmd.reject    = !cfg.link_open;
      cmd.byte_v    = keep_byte;
      cmd.end_v     = end_emit;
      cmd.data      = data_out;
      cmd.opcode    = opcode_ff;
      cmd.final_bit = final_ff;
      cmd.length    = kept_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wfr_pkg::PH_HDR0;
         cnt_ff    <= 3'd0;
         remain_ff <= 64'd0;
         offset_ff <= 2'd0;
         key_ff    <= 32'd0;
         masked_ff <= 1'b0;
         final_ff  <= 1'b0;
         opcode_ff <= 4'd0;
         kept_ff   <= 17'd0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         remain_ff <= remain_in;
         offset_ff <= offset_in;
         key_ff    <= key_in;
         masked_ff <= masked_in;
         final_ff  <= final_in;
         opcode_ff <= opcode_in;
         kept_ff   <= kept_in;
      end
   end

endmodule

@@ rtl/core/wfr_cmd_fifo.sv @@
module wfr_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wfr_pkg::cmd_type wr_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output wfr_pkg::cmd_type head
);

   wfr_pkg::cmd_type mem_ff [wfr_pkg::CMD_DEPTH];

   logic [wfr_pkg::CMD_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [wfr_pkg::CMD_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [wfr_pkg::CMD_AW:0]   count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full    = (count_ff == (wfr_pkg::CMD_AW+1)'(wfr_pkg::CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/wfr_emitter.sv @@
module wfr_emitter (
   input  logic             clock,
   input  logic             reset,
   input  wfr_pkg::cmd_type head,
   input  logic             head_empty,
   output logic             head_pop,
   input  logic             pop,
   output logic [1:0]       kind,
   output logic [7:0]       data_byte,
   output logic [3:0]       frame_opcode,
   output logic             frame_final,
   output logic [16:0]      message_length
);

   // set once the byte half of a byte-plus-end entry has gone out
   logic second_ff, second_in;
   logic take;
   logic two_words;

   assign take      = pop && !head_empty;
   assign two_words = head.byte_v && head.end_v;
   assign head_pop  = take && (!two_words || second_ff);

   always_comb begin
      if (head.reject) begin
         kind = wfr_pkg::KIND_REJECT;
      end else if (head.byte_v && !second_ff) begin
         kind = wfr_pkg::KIND_DATA;
      end else begin
         kind = wfr_pkg::KIND_END;
      end
      data_byte      = (kind == wfr_pkg::KIND_DATA) ? head.data : 8'd0;
      frame_opcode   = head.opcode;
      frame_final    = head.final_bit;
      message_length = head.length;

      second_in = second_ff;
      if (take) begin
         second_in = two_words && !second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

@@ rtl/core/websocket_frame_receiver.sv @@
// channel  | direction | handshake    | payload
// req      | in        | push / full  | req_rx_byte
// rsp      | out       | empty / pop  | rsp_kind, rsp_data_byte, rsp_frame_opcode,
//          |           |              | rsp_frame_final, rsp_message_length
// csr      | in        | csr_we       | csr_index, csr_data
//
// one byte accepted per cycle while full is low; the parser updates its frame state in the cycle
// a byte is taken and queues any resulting word for the emitter in the registered queue
// the last payload byte of a frame can yield two results, drained one per pop
// full rises when the four-entry queue between parser and emitter fills
// synchronous reset clears parser state, queue pointers, link open; capacity goes to 1024
module websocket_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_frame_final,
   output logic [16:0] rsp_message_length,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [16:0] csr_data
);

   logic             link_open_ff;
   logic [16:0]      capacity_ff;
   wfr_pkg::cfg_type cfg;
   logic             accept;
   logic             cmd_push;
   wfr_pkg::cmd_type cmd;
   wfr_pkg::cmd_type head;
   logic             head_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_open_ff <= 1'b0;
         capacity_ff  <= wfr_pkg::CAP_RESET;
      end else if (csr_we) begin
         if (csr_index == wfr_pkg::CSR_LINK_OPEN) begin
            link_open_ff <= csr_data[0];
         end
         if (csr_index == wfr_pkg::CSR_CAPACITY) begin
            capacity_ff <= csr_data;
         end
      end
   end

   // anything above 64k counts as 64k
   assign cfg    = {link_open_ff, capacity_ff[16] ? wfr_pkg::CAP_MAX : capacity_ff};
   assign accept = push && !full;

   wfr_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   wfr_cmd_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_cmd (cmd),
      .full   (full),
      .pop    (head_pop),
      .empty  (empty),
      .head   (head)
   );

   wfr_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_empty     (empty),
      .head_pop       (head_pop),
      .pop            (pop),
      .kind           (rsp_kind),
      .data_byte      (rsp_data_byte),
      .frame_opcode   (rsp_frame_opcode),
      .frame_final    (rsp_frame_final),
      .message_length (rsp_message_length)
   );

endmodule

@@ rtl/core/wfr_checker.sv @@
module wfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [3:0]  rsp_frame_opcode,
   input logic        rsp_frame_final,
   input logic [16:0] rsp_message_length
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_held_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_kind) && $stable(rsp_data_byte)
                            && $stable(rsp_frame_opcode) && $stable(rsp_frame_final)
                            && $stable(rsp_message_length)))
      else $error("stalled word changed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_kind == wfr_pkg::KIND_DATA || rsp_kind == wfr_pkg::KIND_END
                  || rsp_kind == wfr_pkg::KIND_REJECT))
      else $error("illegal result kind");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != wfr_pkg::KIND_DATA) |-> rsp_data_byte == 8'd0)
      else $error("non-payload word carries data");

   a_payload_counted: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == wfr_pkg::KIND_DATA) |-> rsp_message_length != 17'd0)
      else $error("payload word with zero message length");

endmodule

bind websocket_frame_receiver wfr_checker u_wfr_checker (
   .clock              (clock),
   .reset              (reset),
   .empty              (empty),
   .pop                (pop),
   .rsp_kind           (rsp_kind),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_frame_opcode   (rsp_frame_opcode),
   .rsp_frame_final    (rsp_frame_final),
   .rsp_message_length (rsp_message_length)
);

@@ bench/tb_websocket_frame_receiver.sv @@
module tb_websocket_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [3:0]  opcode;
      logic        fin_bit;
      logic [16:0] length;
   } rx_word_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_OPEN, ROW_CAP} row_op_type;

   typedef struct packed {
      row_op_type  op;
      logic [16:0] val;
      logic        typed;
      rx_word_type want;
   } plan_row_type;

   localparam int ITEMS        = 1550;
   localparam int CALM_ITEMS   = 200;
   localparam int QUIET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PLAN_ROWS    = 28;
   localparam rx_word_type NO_WORD = '0;

   logic        clock;
   logic        reset       = 1'b1;
   logic        push        = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        empty;
   logic        pop         = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_frame_final;
   logic [16:0] rsp_message_length;
   logic        csr_we      = 1'b0;
   logic        csr_index   = wfr_pkg::CSR_LINK_OPEN;
   logic [16:0] csr_data    = '0;

   websocket_frame_receiver dut (.*);

   // directed rows; typed rows carry a word that is plain from the frame layout
   plan_row_type plan [0:PLAN_ROWS-1] = '{
      // link closed after reset
      {ROW_BYTE, 17'h000, 1'b1, wfr_pkg::KIND_REJECT, 8'h00, 4'h0, 1'b0, 17'd0},
      {ROW_BYTE, 17'h0FF, 1'b1, wfr_pkg::KIND_REJECT, 8'h00, 4'h0, 1'b0, 17'd0},
      {ROW_CAP,  17'd3,   1'b0, NO_WORD},
      {ROW_OPEN, 17'd1,   1'b0, NO_WORD},
      // masked text fragment of two bytes, no fin
      {ROW_BYTE, 17'h001, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h082, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h0FF, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h000, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h0AA, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h055, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h00F, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h0F0, 1'b0, NO_WORD},
      // fin continuation with 16-bit length, fills capacity after one byte
      {ROW_BYTE, 17'h080, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h07E, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h000, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h003, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h011, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h022, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h033, 1'b0, NO_WORD},
      // empty fin frame, top opcode, ends on its length byte
      {ROW_BYTE, 17'h08F, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h000, 1'b1, wfr_pkg::KIND_END, 8'h00, 4'hF, 1'b1, 17'd0},
      {ROW_OPEN, 17'd0,   1'b0, NO_WORD},
      {ROW_BYTE, 17'h080, 1'b1, wfr_pkg::KIND_REJECT, 8'h00, 4'hF, 1'b1, 17'd0},
      {ROW_OPEN, 17'd1,   1'b0, NO_WORD},
      // zero capacity keeps nothing, every frame closes the message
      {ROW_CAP,  17'd0,   1'b0, NO_WORD},
      {ROW_BYTE, 17'h000, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h001, 1'b0, NO_WORD},
      {ROW_BYTE, 17'h05A, 1'b1, wfr_pkg::KIND_END, 8'h00, 4'h0, 1'b0, 17'd0}
   };

   // deframer copy
   bit                 cfg_open;
   logic [16:0]        cfg_cap;
   wfr_pkg::phase_type parse_phase;
   logic [2:0]         hdr_count;
   logic [63:0]        frame_len;
   logic [63:0]        frame_pos;
   logic [31:0]        mask_key_q;
   logic               frame_masked;
   logic               frame_fin;
   logic [3:0]         frame_op;
   logic [16:0]        kept_bytes;

   rx_word_type byte_words[$];
   rx_word_type deframed_words[$];
   logic [7:0]  byte_stream[$];

   bit calm        = 1'b0;
   bit sender_gaps = 1'b1;
   bit rsp_gaps    = 1'b1;
   int stall_left  = 0;
   int mismatch_count = 0;
   int sent        = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [16:0] capacity_limit();
      return (cfg_cap > wfr_pkg::CAP_MAX) ? wfr_pkg::CAP_MAX : cfg_cap;
   endfunction

   function automatic void emit(input logic [1:0] kind, input logic [7:0] data);
      byte_words.push_back({kind, data, frame_op, frame_fin, kept_bytes});
   endfunction

   function automatic void end_frame();
      parse_phase = wfr_pkg::PH_HDR0;
      hdr_count   = '0;
      frame_pos   = '0;
      if (frame_fin || kept_bytes >= capacity_limit()) begin
         emit(wfr_pkg::KIND_END, 8'h00);
         kept_bytes = '0;
      end
   endfunction

   function automatic void end_header();
      hdr_count = '0;
      frame_pos = '0;
      if (frame_masked) begin
         parse_phase = wfr_pkg::PH_MASK;
      end else if (frame_len == 0) begin
         end_frame();
      end else begin
         parse_phase = wfr_pkg::PH_PAYLOAD;
      end
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      int sh;
      logic [7:0] d;
      if (!cfg_open) begin
         emit(wfr_pkg::KIND_REJECT, 8'h00);
         return;
      end
      case (parse_phase)
         wfr_pkg::PH_HDR0: begin
            frame_fin   = b[7];
            frame_op    = b[3:0];
            parse_phase = wfr_pkg::PH_HDR1;
         end
         wfr_pkg::PH_HDR1: begin
            frame_masked = b[7];
            mask_key_q   = '0;
            frame_len    = '0;
            hdr_count    = '0;
            if (b[6:0] == wfr_pkg::LEN_EXT16) begin
               parse_phase = wfr_pkg::PH_EXT16;
            end else if (b[6:0] == wfr_pkg::LEN_EXT64) begin
               parse_phase = wfr_pkg::PH_EXT64;
            end else begin
               frame_len = 64'(b[6:0]);
               end_header();
            end
         end
         wfr_pkg::PH_EXT16, wfr_pkg::PH_EXT64: begin
            frame_len = {frame_len[55:0], b};
            hdr_count = hdr_count + 3'd1;
            if ((parse_phase == wfr_pkg::PH_EXT16 && hdr_count == wfr_pkg::EXT16_BYTES) ||
                (parse_phase == wfr_pkg::PH_EXT64 && hdr_count == wfr_pkg::EXT64_WRAP))
               end_header();
         end
         wfr_pkg::PH_MASK: begin
            mask_key_q = {mask_key_q[23:0], b};
            hdr_count  = hdr_count + 3'd1;
            if (hdr_count == wfr_pkg::KEY_BYTES) begin
               hdr_count = '0;
               if (frame_len == 0) end_frame();
               else parse_phase = wfr_pkg::PH_PAYLOAD;
            end
         end
         wfr_pkg::PH_PAYLOAD: begin
            // key byte follows the offset in the frame, first key byte first
            sh = 8 * (3 - int'(frame_pos[1:0]));
            d  = frame_masked ? (b ^ mask_key_q[sh +: 8]) : b;
            if (kept_bytes < capacity_limit()) begin
               kept_bytes = kept_bytes + 17'd1;
               emit(wfr_pkg::KIND_DATA, d);
            end
            frame_pos = frame_pos + 64'd1;
            if (frame_pos >= frame_len) end_frame();
         end
         default: begin
            parse_phase = wfr_pkg::PH_HDR0;
            hdr_count   = '0;
         end
      endcase
   endfunction

   // one well-formed frame with random header bits and content
   function automatic void build_frame();
      int          r;
      int          flen;
      logic        m;
      logic [63:0] wide;
      r = $urandom_range(0, 99);
      m = 1'($urandom_range(0, 1));
      byte_stream.push_back(8'($urandom));
      if (r < 55) flen = $urandom_range(0, 12);
      else if (r < 65) flen = $urandom_range(13, 40);
      else if (r < 70) flen = $urandom_range(41, 125);
      else if (r < 83) flen = $urandom_range(0, 30);
      else if (r < 85) flen = $urandom_range(126, 700);
      else flen = $urandom_range(0, 20);
      wide = 64'(flen);
      if (r < 70) begin
         byte_stream.push_back({m, 7'(flen)});
      end else if (r < 85) begin
         byte_stream.push_back({m, wfr_pkg::LEN_EXT16});
         byte_stream.push_back(wide[15:8]);
         byte_stream.push_back(wide[7:0]);
      end else begin
         byte_stream.push_back({m, wfr_pkg::LEN_EXT64});
         for (int i = 7; i >= 0; i--) byte_stream.push_back(wide[8*i +: 8]);
      end
      if (m) repeat (4) byte_stream.push_back(8'($urandom));
      for (int j = 0; j < flen; j++) byte_stream.push_back(8'($urandom));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic typed, input rx_word_type want);
      push        <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      byte_words.delete();
      deframe_byte(b);
      if (typed) begin
         deframed_words.push_back(want);
      end else begin
         foreach (byte_words[k]) deframed_words.push_back(byte_words[k]);
      end
   endtask

   task automatic sender_pause();
      if (sender_gaps && !calm && $urandom_range(0, 99) < 12) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // all words drained, then a quiet wait for bytes that give no word
   task automatic wait_quiet();
      push <= 1'b0;
      @(posedge clock);
      while (deframed_words.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [16:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      if (idx == wfr_pkg::CSR_LINK_OPEN) cfg_open = val[0];
      else cfg_cap = val;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rx_word_type got;
      rx_word_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got = {rsp_kind, rsp_data_byte, rsp_frame_opcode, rsp_frame_final,
                   rsp_message_length};
            if (deframed_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: kind %0d data %02h opcode %0h final %0b length %0d",
                           got.kind, got.data, got.opcode, got.fin_bit, got.length);
            end else begin
               want = deframed_words.pop_front();
               if (got.kind !== want.kind || got.data !== want.data ||
                   got.opcode !== want.opcode || got.fin_bit !== want.fin_bit ||
                   got.length !== want.length) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp %0d %02h %0h %0b %0d got %0d %02h %0h %0b %0d",
                              want.kind, want.data, want.opcode, want.fin_bit, want.length,
                              got.kind, got.data, got.opcode, got.fin_bit, got.length);
               end
            end
         end
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else if (rsp_gaps && !calm && $urandom_range(0, 99) < 10) begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 14);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("websocket_frame_receiver verification failed");
         $finish;
      end
   end

   initial begin
      logic [16:0] cap_pick;
      bit          open_pick;
      bit          tail_masked;
      int          n;
      cfg_open     = 1'b0;
      cfg_cap      = wfr_pkg::CAP_RESET;
      parse_phase  = wfr_pkg::PH_HDR0;
      hdr_count    = '0;
      frame_len    = '0;
      frame_pos    = '0;
      mask_key_q   = '0;
      frame_masked = 1'b0;
      frame_fin    = 1'b0;
      frame_op     = '0;
      kept_bytes   = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         case (plan[i].op)
            ROW_BYTE: begin
               send_byte(plan[i].val[7:0], plan[i].typed, plan[i].want);
               sender_pause();
            end
            ROW_OPEN: begin
               wait_quiet();
               write_reg(wfr_pkg::CSR_LINK_OPEN, plan[i].val);
            end
            default: begin
               wait_quiet();
               write_reg(wfr_pkg::CSR_CAPACITY, plan[i].val);
            end
         endcase
      end

      // phases may split a frame; closed phases send loose bytes outside the frame stream
      while (sent < ITEMS || byte_stream.size() != 0) begin
         wait_quiet();
         if ($urandom_range(0, 99) < 60) begin
            case ($urandom_range(0, 9))
               0:       cap_pick = 17'd0;
               1:       cap_pick = 17'd1;
               2:       cap_pick = 17'($urandom_range(2, 6));
               3:       cap_pick = 17'($urandom_range(7, 40));
               4:       cap_pick = 17'($urandom_range(41, 600));
               5:       cap_pick = wfr_pkg::CAP_MAX - 17'd1;
               6:       cap_pick = wfr_pkg::CAP_MAX;
               7:       cap_pick = 17'h1FFFF;
               8:       cap_pick = 17'($urandom_range(65537, 131070));
               default: cap_pick = wfr_pkg::CAP_RESET;
            endcase
            write_reg(wfr_pkg::CSR_CAPACITY, cap_pick);
         end
         open_pick = ($urandom_range(0, 99) < 85);
         write_reg(wfr_pkg::CSR_LINK_OPEN, {16'd0, open_pick});
         calm        = (sent >= ITEMS - CALM_ITEMS);
         sender_gaps = !calm && ($urandom_range(0, 3) != 0);
         rsp_gaps    = !calm && ($urandom_range(0, 3) != 0);
         if (!open_pick) begin
            repeat ($urandom_range(1, 8)) begin
               send_byte(8'($urandom), 1'b0, NO_WORD);
               sender_pause();
            end
         end else begin
            n = $urandom_range(20, 120);
            for (int i = 0; i < n && (sent < ITEMS || byte_stream.size() != 0); i++) begin
               if (byte_stream.size() == 0) build_frame();
               send_byte(byte_stream.pop_front(), 1'b0, NO_WORD);
               sent++;
               sender_pause();
            end
         end
      end

      // 64-bit length with the top bit set: the frame never ends, capacity fills
      wait_quiet();
      write_reg(wfr_pkg::CSR_CAPACITY, 17'($urandom_range(1, 6)));
      write_reg(wfr_pkg::CSR_LINK_OPEN, 17'd1);
      tail_masked = 1'($urandom_range(0, 1));
      byte_stream.push_back(8'($urandom));
      byte_stream.push_back({tail_masked, wfr_pkg::LEN_EXT64});
      byte_stream.push_back(8'h80 | 8'($urandom));
      repeat (7) byte_stream.push_back(8'($urandom));
      if (tail_masked) repeat (4) byte_stream.push_back(8'($urandom));
      repeat (40) byte_stream.push_back(8'($urandom));
      while (byte_stream.size() != 0) send_byte(byte_stream.pop_front(), 1'b0, NO_WORD);

      push <= 1'b0;
      while (deframed_words.size() != 0) @(posedge clock);
      repeat (4 * QUIET_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && deframed_words.size() == 0) begin
         $display("websocket_frame_receiver verification clean");
      end else begin
         $display("websocket_frame_receiver verification failed");
      end
      $finish;
   end

endmodule
